FILE: rtl/psg_pkg.sv
package psg_pkg;

    localparam int unsigned PERIOD_W = 10;
    localparam int unsigned ATTEN_W  = 4;
    localparam int unsigned LEVEL_W  = 15;
    localparam int unsigned SUM_W    = 17;
    localparam int unsigned LFSR_W   = 16;
    localparam int unsigned SEL_W    = 3;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h8000;
    localparam logic [ATTEN_W-1:0] ATTEN_SILENT = 4'hf;

    // Item kinds carried on tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Register selects
    localparam logic [SEL_W-1:0] SEL_TONE0_PERIOD = 3'd0;
    localparam logic [SEL_W-1:0] SEL_TONE0_ATTEN  = 3'd1;
    localparam logic [SEL_W-1:0] SEL_TONE1_PERIOD = 3'd2;
    localparam logic [SEL_W-1:0] SEL_TONE1_ATTEN  = 3'd3;
    localparam logic [SEL_W-1:0] SEL_TONE2_PERIOD = 3'd4;
    localparam logic [SEL_W-1:0] SEL_TONE2_ATTEN  = 3'd5;
    localparam logic [SEL_W-1:0] SEL_NOISE_CTRL   = 3'd6;
    localparam logic [SEL_W-1:0] SEL_NOISE_ATTEN  = 3'd7;

    // Noise rate codes (control bits 1..0)
    localparam logic [1:0] RATE_16   = 2'd0;
    localparam logic [1:0] RATE_32   = 2'd1;
    localparam logic [1:0] RATE_64   = 2'd2;
    localparam logic [1:0] RATE_TONE = 2'd3;

    localparam logic [PERIOD_W-1:0] RELOAD_16 = 10'h010;
    localparam logic [PERIOD_W-1:0] RELOAD_32 = 10'h020;
    localparam logic [PERIOD_W-1:0] RELOAD_64 = 10'h040;

    typedef struct packed {
        logic tick;
        logic period_lo_we;
        logic period_hi_we;
        logic atten_we;
    } tone_ctl_t;

    typedef struct packed {
        logic tick;
        logic ctrl_we;
        logic atten_we;
    } noise_ctl_t;

    function automatic logic [LEVEL_W-1:0] atten_level(input logic [ATTEN_W-1:0] att);
        logic [LEVEL_W-1:0] lvl;
        unique case (att)
            4'd0:    lvl = 15'd32767;
            4'd1:    lvl = 15'd26028;
            4'd2:    lvl = 15'd20675;
            4'd3:    lvl = 15'd16422;
            4'd4:    lvl = 15'd13045;
            4'd5:    lvl = 15'd10362;
            4'd6:    lvl = 15'd8231;
            4'd7:    lvl = 15'd6568;
            4'd8:    lvl = 15'd5193;
            4'd9:    lvl = 15'd4125;
            4'd10:   lvl = 15'd3277;
            4'd11:   lvl = 15'd2603;
            4'd12:   lvl = 15'd2067;
            4'd13:   lvl = 15'd1642;
            4'd14:   lvl = 15'd1304;
            default: lvl = 15'd0;
        endcase
        return lvl;
    endfunction

endpackage

FILE: rtl/psg_tone.sv
module psg_tone
    import psg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  tone_ctl_t           ctl,
    input  logic [7:0]          data,
    output logic [PERIOD_W-1:0] period,
    output logic [LEVEL_W-1:0]  level_next
);

    logic [PERIOD_W-1:0] period_reg;
    logic [ATTEN_W-1:0]  atten_reg;
    logic [PERIOD_W-1:0] count_reg, count_next;
    logic                phase_reg, phase_next;
    logic [LEVEL_W-1:0]  level_reg;
    logic [PERIOD_W-1:0] count_dec;

    assign count_dec = count_reg - PERIOD_W'(1);

    always_comb
    begin
        count_next = count_reg;
        phase_next = phase_reg;
        level_next = level_reg;
        if (ctl.tick)
        begin
            if (count_reg != '0)
            begin
                count_next = count_dec;
                if (count_dec == '0)
                begin
                    count_next = period_reg;
                    phase_next = ~phase_reg;
                end
                level_next = phase_next ? atten_level(atten_reg) : '0;
            end
            else
            begin
                // zero counter: load only
                count_next = period_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= '0;
            atten_reg  <= ATTEN_SILENT;
            count_reg  <= '0;
            phase_reg  <= 1'b0;
            level_reg  <= '0;
        end
        else
        begin
            if (ctl.period_lo_we)
                period_reg <= {period_reg[PERIOD_W-1:4], data[3:0]};
            else if (ctl.period_hi_we)
                period_reg <= {data[5:0], period_reg[3:0]};
            if (ctl.atten_we)
                atten_reg <= data[3:0];
            count_reg <= count_next;
            phase_reg <= phase_next;
            level_reg <= level_next;
        end
    end

    assign period = period_reg;

endmodule

FILE: rtl/psg_noise.sv
module psg_noise
    import psg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  noise_ctl_t          ctl,
    input  logic [7:0]          data,
    input  logic [PERIOD_W-1:0] tone2_period,
    output logic [LEVEL_W-1:0]  level_next
);

    logic [ATTEN_W-1:0]  ctrl_reg;
    logic [ATTEN_W-1:0]  atten_reg;
    logic [PERIOD_W-1:0] reload_reg, reload_sel;
    logic [PERIOD_W-1:0] count_reg, count_next;
    logic                phase_reg, phase_next;
    logic [LFSR_W-1:0]   lfsr_reg, lfsr_next;
    logic [LEVEL_W-1:0]  level_reg;
    logic [PERIOD_W-1:0] count_dec;
    logic                feedback;

    assign count_dec = count_reg - PERIOD_W'(1);
    assign feedback  = ctrl_reg[2] ? (lfsr_reg[0] ^ lfsr_reg[3]) : lfsr_reg[0];

    always_comb
    begin
        unique case (data[1:0])
            RATE_16:   reload_sel = RELOAD_16;
            RATE_32:   reload_sel = RELOAD_32;
            RATE_64:   reload_sel = RELOAD_64;
            RATE_TONE: reload_sel = tone2_period;
            default:   reload_sel = tone2_period;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        phase_next = phase_reg;
        lfsr_next  = lfsr_reg;
        level_next = level_reg;
        if (ctl.tick)
        begin
            if (count_reg != '0)
            begin
                count_next = count_dec;
                if (count_dec == '0)
                begin
                    count_next = reload_reg;
                    phase_next = ~phase_reg;
                    // shift on the rising phase only
                    if (phase_next)
                    begin
                        level_next = lfsr_reg[0] ? atten_level(atten_reg) : '0;
                        lfsr_next  = {feedback, lfsr_reg[LFSR_W-1:1]};
                    end
                end
            end
            else
            begin
                count_next = reload_reg;
            end
        end
        else if (ctl.ctrl_we)
        begin
            lfsr_next = LFSR_SEED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg   <= '0;
            atten_reg  <= ATTEN_SILENT;
            reload_reg <= '0;
            count_reg  <= '0;
            phase_reg  <= 1'b0;
            lfsr_reg   <= LFSR_SEED;
            level_reg  <= '0;
        end
        else
        begin
            if (ctl.ctrl_we)
            begin
                ctrl_reg   <= data[3:0];
                reload_reg <= reload_sel;
            end
            if (ctl.atten_we)
                atten_reg <= data[3:0];
            count_reg <= count_next;
            phase_reg <= phase_next;
            lfsr_reg  <= lfsr_next;
            level_reg <= level_next;
        end
    end

endmodule

FILE: rtl/psg_tone_noise_generator_unit.sv
// Three square-wave tone channels and one noise channel. Each input item is
// either a register write byte (tuser = 0, byte on tdata) or one generator
// tick (tuser = 1). A tick returns one result item with the four channel
// levels and their sum; a write returns nothing. One item is taken every
// clock cycle while the stream is not held back: an item is first held in
// the input register, then updates the channel state, and a tick's result
// lands in the output register. The output register is the only thing that
// can hold the stream back, and only while a tick result waits.
module psg_tone_noise_generator_unit
    import psg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data[7:0]
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    // tone_a_level[14:0], tone_b_level[29:15], tone_c_level[44:30],
    // noise_level[59:45], mix_sum[76:60], zero[79:77]
    output logic [79:0] m_tdata
);

    logic        in_valid_reg;
    logic        in_op_reg;
    logic [7:0]  in_data_reg;
    logic        m_tvalid_reg;
    logic [79:0] m_tdata_reg;
    logic        advance;
    logic        is_tick;
    logic        is_write;
    logic        latch;
    logic [SEL_W-1:0] sel_reg, sel_eff;

    tone_ctl_t           tone_ctl [3];
    noise_ctl_t          noise_ctl;
    logic [PERIOD_W-1:0] tone_period [3];
    logic [LEVEL_W-1:0]  tone_level_next [3];
    logic [LEVEL_W-1:0]  noise_level_next;
    logic [SUM_W-1:0]    mix_sum;

    // advance the held item unless it is a tick blocked by an unread result
    assign advance  = in_valid_reg && ((in_op_reg == OP_WRITE) || !m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign is_tick  = advance && (in_op_reg == OP_TICK);
    assign is_write = advance && (in_op_reg == OP_WRITE);
    assign latch    = in_data_reg[7];
    assign sel_eff  = latch ? in_data_reg[6:4] : sel_reg;

    for (genvar i = 0; i < 3; i++)
    begin : g_tone
        always_comb
        begin
            tone_ctl[i].tick         = is_tick;
            tone_ctl[i].period_lo_we = is_write && !sel_eff[0]
                                       && (sel_eff[2:1] == 2'(i)) && latch;
            tone_ctl[i].period_hi_we = is_write && !sel_eff[0]
                                       && (sel_eff[2:1] == 2'(i)) && !latch;
            tone_ctl[i].atten_we     = is_write && sel_eff[0]
                                       && (sel_eff[2:1] == 2'(i));
        end

        psg_tone u_tone (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (tone_ctl[i]),
            .data       (in_data_reg),
            .period     (tone_period[i]),
            .level_next (tone_level_next[i])
        );
    end

    always_comb
    begin
        noise_ctl.tick     = is_tick;
        noise_ctl.ctrl_we  = is_write && (sel_eff == SEL_NOISE_CTRL);
        noise_ctl.atten_we = is_write && (sel_eff == SEL_NOISE_ATTEN);
    end

    psg_noise u_noise (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (noise_ctl),
        .data         (in_data_reg),
        .tone2_period (tone_period[2]),
        .level_next   (noise_level_next)
    );

    assign mix_sum = SUM_W'(tone_level_next[0]) + SUM_W'(tone_level_next[1])
                   + SUM_W'(tone_level_next[2]) + SUM_W'(noise_level_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            sel_reg      <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (is_write && latch)
                sel_reg <= in_data_reg[6:4];
            if (is_tick)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg   <= s_tuser;
            in_data_reg <= s_tdata;
        end
        if (is_tick)
            m_tdata_reg <= {3'b000, mix_sum, noise_level_next, tone_level_next[2],
                            tone_level_next[1], tone_level_next[0]};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: verif/testbench.sv
module testbench;
    import psg_pkg::*;

    // Result item as carried on m_tdata, lowest field last
    typedef struct packed {
        logic [2:0]         pad;
        logic [SUM_W-1:0]   mix_sum;
        logic [LEVEL_W-1:0] noise_level;
        logic [LEVEL_W-1:0] tone_c_level;
        logic [LEVEL_W-1:0] tone_b_level;
        logic [LEVEL_W-1:0] tone_a_level;
    } level_frame_t;

    typedef struct {
        logic         op;
        logic [7:0]   data;
        bit           fixed;
        level_frame_t want;
    } stim_row_t;

    localparam int RUN_LIMIT    = 200000;
    localparam int RANDOM_ITEMS = 600;
    localparam int QUIET_TAIL   = 90;
    localparam int DRAIN_CYCLES = 8;
    localparam int SHOW_LIMIT   = 10;
    localparam int WHITE_BIT    = 2;

    localparam logic [LEVEL_W-1:0] LEVELS [0:15] = '{
        15'd32767, 15'd26028, 15'd20675, 15'd16422, 15'd13045, 15'd10362, 15'd8231,
        15'd6568, 15'd5193, 15'd4125, 15'd3277, 15'd2603, 15'd2067, 15'd1642,
        15'd1304, 15'd0
    };

    localparam logic [SEL_W-1:0] PERIOD_SEL [0:2] =
        '{SEL_TONE0_PERIOD, SEL_TONE1_PERIOD, SEL_TONE2_PERIOD};
    localparam logic [SEL_W-1:0] ATTEN_SEL [0:2] =
        '{SEL_TONE0_ATTEN, SEL_TONE1_ATTEN, SEL_TONE2_ATTEN};

    localparam level_frame_t SILENT_FRAME = '0;
    localparam level_frame_t TONE_A_FULL  = '{pad: 3'd0, mix_sum: 17'd32767,
        noise_level: 15'd0, tone_c_level: 15'd0, tone_b_level: 15'd0,
        tone_a_level: 15'd32767};

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;

    // Side channel that travels with the item on the input bus
    bit           row_fixed;
    level_frame_t row_want;
    bit           quiet;

    level_frame_t frames_due [$];
    int           errors;
    int           ticks_taken;
    int           writes_taken;
    int           frames_checked;
    int           sent_count;
    int           cycles;

    // Generator state mirrored by the predictor
    logic [SEL_W-1:0]    sel_q;
    logic [PERIOD_W-1:0] tone_per [0:2];
    logic [PERIOD_W-1:0] tone_cnt [0:2];
    logic [ATTEN_W-1:0]  tone_att [0:2];
    logic                tone_ph  [0:2];
    logic [LEVEL_W-1:0]  tone_lvl [0:2];
    logic [3:0]          noise_ctl;
    logic [ATTEN_W-1:0]  noise_att;
    logic [PERIOD_W-1:0] noise_reload;
    logic [PERIOD_W-1:0] noise_cnt;
    logic                noise_ph;
    logic [LFSR_W-1:0]   lfsr;
    logic [LEVEL_W-1:0]  noise_lvl;
    int                  noise_shifts;

    psg_tone_noise_generator_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    function automatic logic [7:0] sel_byte(input logic [SEL_W-1:0] sel, input logic [3:0] low);
        return {1'b1, sel, low};
    endfunction

    function automatic stim_row_t stim_row(input logic op, input logic [7:0] d,
                                           input bit fixed, input level_frame_t want);
        stim_row_t r;
        r.op    = op;
        r.data  = d;
        r.fixed = fixed;
        r.want  = want;
        return r;
    endfunction

    task automatic psg_model_step(input logic op, input logic [7:0] d,
                                  output bit emits, output level_frame_t r);
        logic [1:0] ch;
        logic       fb;
        int         i;
        emits = 1'b0;
        r     = '0;
        if (op == OP_WRITE) begin
            if (d[7])
                sel_q = d[6:4];
            ch = sel_q[2:1];
            case (sel_q)
                SEL_TONE0_PERIOD, SEL_TONE1_PERIOD, SEL_TONE2_PERIOD:
                begin
                    if (d[7])
                        tone_per[ch][3:0] = d[3:0];
                    else
                        tone_per[ch][9:4] = d[5:0];
                end
                SEL_TONE0_ATTEN, SEL_TONE1_ATTEN, SEL_TONE2_ATTEN:
                begin
                    tone_att[ch] = d[3:0];
                end
                SEL_NOISE_CTRL:
                begin
                    noise_ctl = d[3:0];
                    lfsr      = LFSR_SEED;
                    case (d[1:0])
                        RATE_16: noise_reload = RELOAD_16;
                        RATE_32: noise_reload = RELOAD_32;
                        RATE_64: noise_reload = RELOAD_64;
                        default: noise_reload = tone_per[2];
                    endcase
                end
                default:
                begin
                    noise_att = d[3:0];
                end
            endcase
        end else begin
            for (i = 0; i < 3; i++) begin
                if (tone_cnt[i] != '0) begin
                    tone_cnt[i] = tone_cnt[i] - 1'b1;
                    if (tone_cnt[i] == '0) begin
                        tone_cnt[i] = tone_per[i];
                        tone_ph[i]  = ~tone_ph[i];
                    end
                    tone_lvl[i] = tone_ph[i] ? LEVELS[tone_att[i]] : '0;
                end else begin
                    tone_cnt[i] = tone_per[i];
                end
            end
            if (noise_cnt != '0) begin
                noise_cnt = noise_cnt - 1'b1;
                if (noise_cnt == '0) begin
                    noise_ph  = ~noise_ph;
                    noise_cnt = noise_reload;
                    if (noise_ph) begin
                        noise_lvl = lfsr[0] ? LEVELS[noise_att] : '0;
                        fb = noise_ctl[WHITE_BIT] ? (lfsr[0] ^ lfsr[3]) : lfsr[0];
                        lfsr = {fb, lfsr[LFSR_W-1:1]};
                        noise_shifts++;
                    end
                end
            end else begin
                noise_cnt = noise_reload;
            end
            emits          = 1'b1;
            r.tone_a_level = tone_lvl[0];
            r.tone_b_level = tone_lvl[1];
            r.tone_c_level = tone_lvl[2];
            r.noise_level  = noise_lvl;
            r.mix_sum      = {2'b00, tone_lvl[0]} + {2'b00, tone_lvl[1]}
                           + {2'b00, tone_lvl[2]} + {2'b00, noise_lvl};
        end
    endtask

    // Call at a falling edge; returns at the falling edge after acceptance
    task automatic push_item(input logic op, input logic [7:0] d,
                             input bit fixed, input level_frame_t want);
        int gap;
        gap = (!quiet && $urandom_range(0, 7) == 0) ? $urandom_range(1, 9) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tuser   <= op;
        s_tdata   <= d;
        row_fixed <= fixed;
        row_want  <= want;
        do
            @(posedge clk);
        while (!s_tready);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic show_mismatch(input string what, input level_frame_t want,
                                 input level_frame_t got);
        errors++;
        if (errors <= SHOW_LIMIT)
            $display("mismatch (%s): want a=%0d b=%0d c=%0d n=%0d sum=%0d pad=%0d, got a=%0d b=%0d c=%0d n=%0d sum=%0d pad=%0d",
                     what, want.tone_a_level, want.tone_b_level, want.tone_c_level,
                     want.noise_level, want.mix_sum, want.pad,
                     got.tone_a_level, got.tone_b_level, got.tone_c_level,
                     got.noise_level, got.mix_sum, got.pad);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < RUN_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("FAIL psg_tone_noise_generator_unit");
        $finish;
    end

    // Predict on every accepted input item
    always @(posedge clk)
    begin : take_items
        bit           emits;
        level_frame_t r;
        if (rst_n && s_tvalid && s_tready) begin
            psg_model_step(s_tuser, s_tdata, emits, r);
            if (emits) begin
                ticks_taken++;
                frames_due.push_back(row_fixed ? row_want : r);
            end else begin
                writes_taken++;
            end
        end
    end

    always @(posedge clk)
    begin : watch_results
        level_frame_t got;
        level_frame_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got = level_frame_t'(m_tdata);
            if (frames_due.size() == 0) begin
                show_mismatch("unexpected item", SILENT_FRAME, got);
            end else begin
                want = frames_due.pop_front();
                frames_checked++;
                if (got.tone_a_level != want.tone_a_level
                    || got.tone_b_level != want.tone_b_level
                    || got.tone_c_level != want.tone_c_level
                    || got.noise_level != want.noise_level
                    || got.mix_sum != want.mix_sum
                    || got.pad != want.pad)
                    show_mismatch($sformatf("result %0d", frames_checked), want, got);
            end
        end
    end

    // Downstream stall bursts
    initial
    begin : drain_side
        int stall;
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (!quiet && rst_n && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 9);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin : main_flow
        stim_row_t plan [$];
        int        target;
        int        seg_len;
        int        pick;
        int        ch;
        int        j;
        logic [5:0] hi;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = OP_WRITE;
        s_tdata   = 8'h00;
        row_fixed = 1'b0;
        row_want  = '0;
        quiet     = 1'b0;
        errors = 0; ticks_taken = 0; writes_taken = 0; frames_checked = 0;
        sent_count = 0; noise_shifts = 0;

        sel_q = '0;
        for (j = 0; j < 3; j++) begin
            tone_per[j] = '0;
            tone_cnt[j] = '0;
            tone_att[j] = ATTEN_SILENT;
            tone_ph[j]  = 1'b0;
            tone_lvl[j] = '0;
        end
        noise_ctl    = '0;
        noise_att    = ATTEN_SILENT;
        noise_reload = '0;
        noise_cnt    = '0;
        noise_ph     = 1'b0;
        lfsr         = LFSR_SEED;
        noise_lvl    = '0;

        // Directed part: reset state, first toggle, extremes, tone-rate noise copy
        plan.push_back(stim_row(OP_TICK,  8'h00, 1'b1, SILENT_FRAME));
        plan.push_back(stim_row(OP_WRITE, sel_byte(SEL_TONE0_ATTEN, 4'h0), 1'b0, '0));
        plan.push_back(stim_row(OP_WRITE, sel_byte(SEL_TONE0_PERIOD, 4'h1), 1'b0, '0));
        // zero countdown only reloads
        plan.push_back(stim_row(OP_TICK,  8'hff, 1'b1, SILENT_FRAME));
        plan.push_back(stim_row(OP_TICK,  8'h00, 1'b1, TONE_A_FULL));
        plan.push_back(stim_row(OP_TICK,  8'h00, 1'b1, SILENT_FRAME));
        plan.push_back(stim_row(OP_WRITE, 8'hff, 1'b0, '0));
        plan.push_back(stim_row(OP_WRITE, 8'h00, 1'b0, '0));
        plan.push_back(stim_row(OP_WRITE, sel_byte(SEL_TONE1_ATTEN, 4'he), 1'b0, '0));
        plan.push_back(stim_row(OP_WRITE, sel_byte(SEL_TONE1_PERIOD, 4'hf), 1'b0, '0));
        plan.push_back(stim_row(OP_WRITE, 8'h3f, 1'b0, '0));
        plan.push_back(stim_row(OP_WRITE, sel_byte(SEL_TONE2_PERIOD, 4'h2), 1'b0, '0));
        plan.push_back(stim_row(OP_WRITE, 8'h40, 1'b0, '0));
        plan.push_back(stim_row(OP_WRITE, sel_byte(SEL_TONE2_ATTEN, 4'h5), 1'b0, '0));
        plan.push_back(stim_row(OP_WRITE, sel_byte(SEL_NOISE_CTRL, 4'h7), 1'b0, '0));
        // tone 2 change must not reach the copied noise reload
        plan.push_back(stim_row(OP_WRITE, sel_byte(SEL_TONE2_PERIOD, 4'h4), 1'b0, '0));
        plan.push_back(stim_row(OP_WRITE, sel_byte(SEL_NOISE_ATTEN, 4'h0), 1'b0, '0));
        for (j = 0; j < 6; j++)
            plan.push_back(stim_row(OP_TICK, 8'h00, 1'b0, '0));
        plan.push_back(stim_row(OP_WRITE, sel_byte(SEL_NOISE_CTRL, 4'h0), 1'b0, '0));
        plan.push_back(stim_row(OP_TICK,  8'h00, 1'b0, '0));
        plan.push_back(stim_row(OP_WRITE, sel_byte(SEL_NOISE_CTRL, 4'hc), 1'b0, '0));
        plan.push_back(stim_row(OP_TICK,  8'h80, 1'b0, '0));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[k])
            push_item(plan[k].op, plan[k].data, plan[k].fixed, plan[k].want);

        // Random part: segments with one noise setup each, so the shift register can run
        target = sent_count + RANDOM_ITEMS;
        while (sent_count < target) begin
            if ($urandom_range(0, 1)) begin
                push_item(OP_WRITE, sel_byte(SEL_TONE2_PERIOD, 4'($urandom_range(1, 3))),
                          1'b0, '0);
                push_item(OP_WRITE, {2'b00, 6'd0}, 1'b0, '0);
            end
            push_item(OP_WRITE, sel_byte(SEL_NOISE_CTRL, 4'($urandom_range(0, 15))), 1'b0, '0);
            push_item(OP_WRITE, sel_byte(SEL_NOISE_ATTEN, 4'($urandom_range(0, 15))), 1'b0, '0);
            seg_len = $urandom_range(50, 110);
            for (j = 0; j < seg_len && sent_count < target; j++) begin
                if (sent_count >= target - QUIET_TAIL)
                    quiet <= 1'b1;
                pick = $urandom_range(0, 99);
                ch   = $urandom_range(0, 2);
                if (pick < 68) begin
                    push_item(OP_TICK, 8'($urandom_range(0, 255)), 1'b0, '0);
                end else if (pick < 84) begin
                    push_item(OP_WRITE, sel_byte(PERIOD_SEL[ch], 4'($urandom_range(0, 15))),
                              1'b0, '0);
                    if ($urandom_range(0, 1)) begin
                        // keep most periods short so phases toggle often
                        hi = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                         : 6'($urandom_range(0, 1));
                        push_item(OP_WRITE, {1'b0, 1'($urandom_range(0, 1)), hi}, 1'b0, '0);
                    end
                end else if (pick < 93) begin
                    push_item(OP_WRITE, sel_byte(ATTEN_SEL[ch], 4'($urandom_range(0, 15))),
                              1'b0, '0);
                end else if (pick < 96) begin
                    push_item(OP_WRITE, sel_byte(SEL_NOISE_ATTEN, 4'($urandom_range(0, 15))),
                              1'b0, '0);
                end else begin
                    push_item(OP_WRITE, 8'($urandom_range(0, 255)), 1'b0, '0);
                end
            end
        end
        s_tvalid <= 1'b0;

        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d ticks and %0d register writes, %0d results compared",
                 ticks_taken, writes_taken, frames_checked);
        $display("noise register shifted %0d times; %0d mismatches", noise_shifts, errors);
        if (errors == 0 && frames_due.size() == 0)
            $display("PASS psg_tone_noise_generator_unit");
        else
            $display("FAIL psg_tone_noise_generator_unit");
        $finish;
    end

endmodule
